// ----- rtl/dsa_pkg.sv -----
// dsa_pkg: shared types and constants of the descriptor slot allocator
// no dependencies
`default_nettype none
package dsa_pkg;
  localparam int unsigned FREE_DEPTH = 1024;
  localparam int unsigned FREE_AW = $clog2(FREE_DEPTH);
  localparam int unsigned FREE_CW = $clog2(FREE_DEPTH + 1);
  localparam int unsigned HW_W = 11;

  localparam logic [1:0] CMD_ALLOC_ANY = 2'd0;
  localparam logic [1:0] CMD_ALLOC_AT = 2'd1;
  localparam logic [1:0] CMD_FREE = 2'd2;
  localparam logic [1:0] CMD_RESET = 2'd3;

  localparam logic [2:0] REG_STRIDE = 3'd0;
  localparam logic [2:0] REG_CPU_BASE = 3'd1;
  localparam logic [2:0] REG_GPU_BASE = 3'd2;
  localparam logic [2:0] REG_GPU_VIS = 3'd3;
  localparam logic [2:0] REG_MAX_COUNT = 3'd4;
  localparam logic [2:0] REG_HEAP_TAG = 3'd5;

  typedef struct packed {
    logic [1:0] command;
    logic [15:0] slot_index;
    logic [63:0] free_cpu_address;
    logic [63:0] free_gpu_address;
    logic [63:0] free_owner_tag;
  } dsa_in_t;

  typedef struct packed {
    logic ok;
    logic [63:0] cpu_address;
    logic [63:0] gpu_address;
    logic [63:0] owner_tag;
    logic has_room;
    logic free_overflow;
  } dsa_out_t;

  typedef struct packed {
    logic [63:0] cpu;
    logic [63:0] gpu;
    logic [63:0] tag;
  } dsa_entry_t;

  // memory port request from the controller
  typedef struct packed {
    logic re;
    logic [FREE_AW-1:0] raddr;
    logic we;
    logic [FREE_AW-1:0] waddr;
    dsa_entry_t wdata;
  } dsa_mem_req_t;
endpackage
`default_nettype wire

// ----- rtl/descriptor_slot_allocator.sv -----
// descriptor_slot_allocator: top level, config registers and unit wiring
// depends on dsa_pkg, dsa_ctrl, dsa_list_ram, dsa_slot_div
`default_nettype none
// Hands out descriptor heap slots from a high-water count and an ordered
// free list held in one synchronous RAM. One transaction at a time: each
// free, reset or allocate finishes before the next is accepted.
// Allocate-at-index walks the list oldest first; each entry goes through
// the serial slot divider (skipped with a zero stride), and a hit then
// compacts the tail one entry at a time, so the worst case grows with
// FREE_DEPTH.
// The result register holds one finished transaction while the next is
// accepted and worked on.
module descriptor_slot_allocator
  import dsa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire dsa_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output dsa_out_t         out_data,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata
);
  logic [15:0] stride_r;
  logic [63:0] cpu_base_r;
  logic [63:0] gpu_base_r;
  logic        gpu_vis_r;
  logic [10:0] max_count_r;
  logic [63:0] heap_tag_r;
  dsa_mem_req_t mem_req;
  dsa_entry_t mem_rdata;
  logic div_start;
  logic [63:0] div_dividend;
  logic div_done;
  logic [63:0] div_quotient;
  logic [FREE_CW-1:0] free_count;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r <= 16'd32;
      cpu_base_r <= '0;
      gpu_base_r <= '0;
      gpu_vis_r <= 1'b0;
      max_count_r <= 11'd1024;
      heap_tag_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STRIDE: stride_r <= cfg_wdata[15:0];
        REG_CPU_BASE: cpu_base_r <= cfg_wdata;
        REG_GPU_BASE: gpu_base_r <= cfg_wdata;
        REG_GPU_VIS: gpu_vis_r <= cfg_wdata[0];
        REG_MAX_COUNT: max_count_r <= cfg_wdata[10:0];
        REG_HEAP_TAG: heap_tag_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  dsa_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data,
    .stride(stride_r), .cpu_base(cpu_base_r), .gpu_base(gpu_base_r),
    .gpu_visible(gpu_vis_r), .max_count(max_count_r), .heap_tag(heap_tag_r),
    .mem_req, .mem_rdata, .div_start, .div_dividend, .div_done,
    .div_quotient, .free_count
  );

  dsa_list_ram u_ram (.clk, .req(mem_req), .rdata(mem_rdata));

  dsa_slot_div u_div (
    .clk, .rst_n, .start(div_start), .dividend(div_dividend),
    .divisor(stride_r), .done(div_done), .quotient(div_quotient)
  );

  // list never exceeds its depth
  a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_count <= FREE_CW'(FREE_DEPTH)) else $error("free count overflow");

  // a successful free grows the list by one
  a_free_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.command == CMD_FREE &&
     free_count < FREE_CW'(FREE_DEPTH)) |=> free_count == $past(free_count) + 1'b1)
    else $error("free did not push");

  // no ram write while idle and nothing accepted
  a_ram_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_stall && !in_valid) |-> !mem_req.we) else $error("stray ram write");
endmodule
`default_nettype wire

// ----- rtl/dsa_list_ram.sv -----
// dsa_list_ram: free list storage, one write and one read port, registered read
// depends on dsa_pkg
`default_nettype none
module dsa_list_ram
  import dsa_pkg::*;
(
  input  wire logic         clk,
  input  wire dsa_mem_req_t req,
  output dsa_entry_t        rdata
);
  dsa_entry_t mem [FREE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end
endmodule
`default_nettype wire

// ----- rtl/dsa_slot_div.sv -----
// dsa_slot_div: radix-2 restoring divider, 64-bit dividend by 16-bit divisor
// depends on dsa_pkg
`default_nettype none
module dsa_slot_div
  import dsa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             done,
  output logic [63:0]      quotient
);
  logic [63:0] quo_r, quo_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] dvs_r;
  logic [6:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;
  logic [16:0] trial;

  // one quotient bit per cycle
  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r[15:0], quo_r[63]};
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = 7'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done = done_r;
  assign quotient = quo_r;
endmodule
`default_nettype wire

// ----- rtl/dsa_ctrl.sv -----
// dsa_ctrl: command sequencer for the allocator, owns counts and list walks
// depends on dsa_pkg
`default_nettype none
module dsa_ctrl
  import dsa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire dsa_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output dsa_out_t         out_data,
  input  wire logic [15:0] stride,
  input  wire logic [63:0] cpu_base,
  input  wire logic [63:0] gpu_base,
  input  wire logic        gpu_visible,
  input  wire logic [10:0] max_count,
  input  wire logic [63:0] heap_tag,
  output dsa_mem_req_t     mem_req,
  input  wire dsa_entry_t  mem_rdata,
  output logic             div_start,
  output logic [63:0]      div_dividend,
  input  wire logic        div_done,
  input  wire logic [63:0] div_quotient,
  output logic [FREE_CW-1:0] free_count
);
  typedef enum logic [3:0] {
    S_IDLE, S_POP_RD, S_POP_WT, S_SRCH_RD, S_SRCH_WT, S_DIV,
    S_SHIFT_RD, S_SHIFT_WR, S_BUILD_MUL, S_BUILD_ADD, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic [HW_W-1:0] hw_r, hw_nxt;
  logic [FREE_CW-1:0] fc_r, fc_nxt;
  logic [FREE_CW-1:0] pos_r, pos_nxt;
  logic [15:0] idx_r, idx_nxt;
  logic [63:0] slot_r, slot_nxt;
  logic [63:0] off_r, off_nxt;
  dsa_entry_t hold_r, hold_nxt;
  dsa_out_t res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;
  dsa_out_t out_r, out_nxt;
  logic [FREE_CW-1:0] pos_inc;

  assign pos_inc = pos_r + 1'b1;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    hw_nxt = hw_r;
    fc_nxt = fc_r;
    pos_nxt = pos_r;
    idx_nxt = idx_r;
    slot_nxt = slot_r;
    off_nxt = off_r;
    hold_nxt = hold_r;
    res_nxt = res_r;
    out_valid_nxt = out_valid_r;
    out_nxt = out_r;
    mem_req = '0;
    div_start = 1'b0;
    div_dividend = mem_rdata.cpu - cpu_base;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          idx_nxt = in_data.slot_index;
          res_nxt = '0;
          case (in_data.command)
            CMD_ALLOC_ANY: begin
              if (fc_r != '0) begin
                pos_nxt = fc_r - 1'b1;
                state_nxt = S_POP_RD;
              end else if ({1'b0, hw_r} + 12'd1 <= {1'b0, max_count}) begin
                slot_nxt = 64'(hw_r);
                hw_nxt = hw_r + 1'b1;
                state_nxt = S_BUILD_MUL;
              end else begin
                state_nxt = S_DONE;
              end
            end
            CMD_ALLOC_AT: begin
              pos_nxt = '0;
              state_nxt = S_SRCH_RD;
            end
            CMD_FREE: begin
              if (fc_r < FREE_CW'(FREE_DEPTH)) begin
                mem_req.we = 1'b1;
                mem_req.waddr = fc_r[FREE_AW-1:0];
                mem_req.wdata.cpu = in_data.free_cpu_address;
                mem_req.wdata.gpu = in_data.free_gpu_address;
                mem_req.wdata.tag = in_data.free_owner_tag;
                fc_nxt = fc_r + 1'b1;
                res_nxt.ok = 1'b1;
              end else begin
                res_nxt.free_overflow = 1'b1;
              end
              state_nxt = S_DONE;
            end
            default: begin
              hw_nxt = '0;
              fc_nxt = '0;
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      // newest entry, no compaction needed
      S_POP_RD: begin
        mem_req.re = 1'b1;
        mem_req.raddr = pos_r[FREE_AW-1:0];
        state_nxt = S_POP_WT;
      end
      S_POP_WT: begin
        res_nxt.ok = 1'b1;
        res_nxt.cpu_address = mem_rdata.cpu;
        res_nxt.gpu_address = mem_rdata.gpu;
        res_nxt.owner_tag = mem_rdata.tag;
        fc_nxt = fc_r - 1'b1;
        state_nxt = S_DONE;
      end
      // walk the list oldest first
      S_SRCH_RD: begin
        if (pos_r < fc_r) begin
          mem_req.re = 1'b1;
          mem_req.raddr = pos_r[FREE_AW-1:0];
          state_nxt = S_SRCH_WT;
        end else if ({1'b0, idx_r} + 17'd1 <= {6'd0, max_count}) begin
          if ({5'd0, idx_r} >= {10'd0, hw_r}) begin
            hw_nxt = HW_W'(idx_r + 16'd1);
          end
          slot_nxt = 64'(idx_r);
          state_nxt = S_BUILD_MUL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SRCH_WT: begin
        hold_nxt = mem_rdata;
        if (stride == '0) begin
          pos_nxt = pos_inc;
          state_nxt = S_SRCH_RD;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (div_quotient == 64'(idx_r)) begin
            res_nxt.ok = 1'b1;
            res_nxt.cpu_address = hold_r.cpu;
            res_nxt.gpu_address = hold_r.gpu;
            res_nxt.owner_tag = hold_r.tag;
            state_nxt = S_SHIFT_RD;
          end else begin
            pos_nxt = pos_inc;
            state_nxt = S_SRCH_RD;
          end
        end
      end
      // compact: move entry pos+1 down to pos
      S_SHIFT_RD: begin
        if (pos_inc < fc_r) begin
          mem_req.re = 1'b1;
          mem_req.raddr = pos_inc[FREE_AW-1:0];
          state_nxt = S_SHIFT_WR;
        end else begin
          fc_nxt = fc_r - 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_SHIFT_WR: begin
        mem_req.we = 1'b1;
        mem_req.waddr = pos_r[FREE_AW-1:0];
        mem_req.wdata = mem_rdata;
        pos_nxt = pos_inc;
        state_nxt = S_SHIFT_RD;
      end
      S_BUILD_MUL: begin
        off_nxt = {32'd0, {16'd0, slot_r[15:0]} * {16'd0, stride}};
        state_nxt = S_BUILD_ADD;
      end
      S_BUILD_ADD: begin
        res_nxt.ok = 1'b1;
        res_nxt.cpu_address = cpu_base + off_r;
        res_nxt.gpu_address = gpu_visible ? gpu_base + off_r : 64'd0;
        res_nxt.owner_tag = heap_tag;
        state_nxt = S_DONE;
      end
      // hand the finished transaction to the result register
      S_DONE: begin
        if (!out_valid_r) begin
          out_nxt = res_r;
          out_nxt.has_room = ({1'b0, hw_r} < {1'b0, max_count}) || (fc_r != '0);
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      hw_r <= '0;
      fc_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hw_r <= hw_nxt;
      fc_r <= fc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    idx_r <= idx_nxt;
    slot_r <= slot_nxt;
    off_r <= off_nxt;
    hold_r <= hold_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_r;
  assign free_count = fc_r;
endmodule
`default_nettype wire

// ----- dv/descriptor_slot_allocator_tb.sv -----
// descriptor_slot_allocator_tb: self-checking testbench of the descriptor slot allocator
// predicts every result from its own copy of the heap state; depends on dsa_pkg and descriptor_slot_allocator
`timescale 1ns / 100ps
module descriptor_slot_allocator_tb;
  import dsa_pkg::*;

  localparam int WATCHDOG_LIMIT = 250000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  dsa_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  dsa_out_t    out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_wdata;

  descriptor_slot_allocator uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // predicted heap state and register copies
  logic [15:0] m_stride = 16'd32;
  logic [63:0] m_cpu_base = '0;
  logic [63:0] m_gpu_base = '0;
  logic        m_gpu_vis = 1'b0;
  logic [10:0] m_max = 11'd1024;
  logic [63:0] m_tag = '0;
  int          high_water = 0;
  dsa_entry_t  freed_handles[$];

  dsa_in_t     pending_cmds[$];
  dsa_out_t    expected_results[$];
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_off_cycles = 0;
  int          quiet_cycles = 0;
  bit          failed = 0;

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic dsa_out_t built_handle(int unsigned slot);
    dsa_out_t r;
    logic [63:0] off;
    r = '0;
    off = 64'(slot) * 64'(m_stride);
    r.ok = 1'b1;
    r.cpu_address = m_cpu_base + off;
    r.gpu_address = m_gpu_vis ? m_gpu_base + off : 64'd0;
    r.owner_tag = m_tag;
    return r;
  endfunction

  function automatic dsa_out_t taken_handle(int pos);
    dsa_out_t r;
    r = '0;
    r.ok = 1'b1;
    r.cpu_address = freed_handles[pos].cpu;
    r.gpu_address = freed_handles[pos].gpu;
    r.owner_tag = freed_handles[pos].tag;
    freed_handles.delete(pos);
    return r;
  endfunction

  // advances the predicted heap by one command
  function automatic dsa_out_t predict_allocation(dsa_in_t cmd);
    dsa_out_t r;
    logic [63:0] diff;
    logic [63:0] quot;
    bit found;
    r = '0;
    found = 0;
    case (cmd.command)
      CMD_ALLOC_ANY: begin
        if (freed_handles.size() > 0) begin
          r = taken_handle(freed_handles.size() - 1);
        end else if (high_water + 1 <= int'(m_max)) begin
          r = built_handle(high_water);
          high_water++;
        end
      end
      CMD_ALLOC_AT: begin
        for (int i = 0; i < freed_handles.size() && !found; i++) begin
          diff = freed_handles[i].cpu - m_cpu_base;
          quot = (m_stride == 0) ? '1 : diff / {48'd0, m_stride};
          if (quot == {48'd0, cmd.slot_index}) begin
            r = taken_handle(i);
            found = 1;
          end
        end
        if (!found && int'(cmd.slot_index) + 1 <= int'(m_max)) begin
          if (int'(cmd.slot_index) >= high_water) high_water = int'(cmd.slot_index) + 1;
          r = built_handle(cmd.slot_index);
        end
      end
      CMD_FREE: begin
        if (freed_handles.size() < FREE_DEPTH) begin
          freed_handles.push_back('{cpu: cmd.free_cpu_address,
                                    gpu: cmd.free_gpu_address,
                                    tag: cmd.free_owner_tag});
          r.ok = 1'b1;
        end else begin
          r.free_overflow = 1'b1;
        end
      end
      default: begin
        high_water = 0;
        freed_handles.delete();
      end
    endcase
    r.has_room = (high_water < int'(m_max)) || (freed_handles.size() != 0);
    return r;
  endfunction

  function automatic dsa_in_t make_cmd(logic [1:0] op, int unsigned slot);
    dsa_in_t c;
    c.command = op;
    c.slot_index = 16'(slot);
    c.free_cpu_address = rand64();
    c.free_gpu_address = rand64();
    c.free_owner_tag = rand64();
    return c;
  endfunction

  // random command; freed addresses mostly land inside real slots
  function automatic dsa_in_t random_cmd();
    dsa_in_t c;
    int unsigned pick;
    int unsigned slot;
    pick = $urandom_range(0, 99);
    if (pick < 30) c = make_cmd(CMD_ALLOC_ANY, $urandom());
    else if (pick < 62) c = make_cmd(CMD_FREE, $urandom());
    else if (pick < 96) c = make_cmd(CMD_ALLOC_AT, 0);
    else c = make_cmd(CMD_RESET, $urandom());
    pick = $urandom_range(0, 9);
    slot = (pick < 8) ? $urandom_range(0, int'(m_max) + 1) :
           (pick == 8) ? 65535 : $urandom_range(0, 65535);
    if (c.command == CMD_ALLOC_AT) c.slot_index = 16'(slot);
    if (c.command == CMD_FREE && $urandom_range(0, 9) < 7) begin
      c.free_cpu_address = m_cpu_base + 64'(slot) * 64'(m_stride)
                         + ((m_stride == 0) ? 64'd0 : 64'($urandom_range(0, m_stride - 1)));
    end
    return c;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // sender: new transaction offered at the falling edge
  bit took_in;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || took_in) begin
      if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_cmds.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_stall <= 1'b1;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // monitor: predict on input transactions, check output transactions
  always @(posedge clk) begin
    dsa_out_t want;
    took_in = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, out_data);
          failed = 1;
        end else begin
          want = expected_results.pop_front();
          if (out_data.ok !== want.ok || out_data.cpu_address !== want.cpu_address ||
              out_data.gpu_address !== want.gpu_address ||
              out_data.owner_tag !== want.owner_tag ||
              out_data.has_room !== want.has_room ||
              out_data.free_overflow !== want.free_overflow) begin
            $display("%0t: mismatch expected %h actual %h", $realtime, want, out_data);
            failed = 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        took_in = 1'b1;
        expected_results.push_back(predict_allocation(in_data));
      end
    end
  end

  // watchdog on cycles with no transaction at all
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (pending_cmds.size() == 0 && expected_results.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || expected_results.size() != 0 || in_valid)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_STRIDE: m_stride = value[15:0];
      REG_CPU_BASE: m_cpu_base = value;
      REG_GPU_BASE: m_gpu_base = value;
      REG_GPU_VIS: m_gpu_vis = value[0];
      REG_MAX_COUNT: m_max = value[10:0];
      default: m_tag = value;
    endcase
  endtask

  task automatic set_heap(logic [15:0] stride, logic [63:0] cbase, logic [63:0] gbase,
                          logic vis, logic [10:0] maxc, logic [63:0] tag);
    write_reg(REG_STRIDE, {48'd0, stride});
    write_reg(REG_CPU_BASE, cbase);
    write_reg(REG_GPU_BASE, gbase);
    write_reg(REG_GPU_VIS, {63'd0, vis});
    write_reg(REG_MAX_COUNT, {53'd0, maxc});
    write_reg(REG_HEAP_TAG, tag);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: defaults, build, reuse, match by index, extremes
    pending_cmds.push_back(make_cmd(CMD_ALLOC_ANY, 0));
    pending_cmds.push_back(make_cmd(CMD_ALLOC_ANY, 0));
    pending_cmds.push_back(make_cmd(CMD_ALLOC_AT, 5));
    pending_cmds.push_back(make_cmd(CMD_ALLOC_AT, 1023));
    pending_cmds.push_back(make_cmd(CMD_ALLOC_AT, 1024));
    pending_cmds.push_back(make_cmd(CMD_ALLOC_AT, 65535));
    pending_cmds.push_back(make_cmd(CMD_FREE, 0));
    pending_cmds[$].free_cpu_address = 64'd96;
    pending_cmds.push_back(make_cmd(CMD_FREE, 0));
    pending_cmds[$].free_cpu_address = 64'd100;
    pending_cmds.push_back(make_cmd(CMD_FREE, 0));
    pending_cmds[$].free_cpu_address = '1;
    pending_cmds.push_back(make_cmd(CMD_ALLOC_AT, 3));
    pending_cmds.push_back(make_cmd(CMD_ALLOC_ANY, 0));
    pending_cmds.push_back(make_cmd(CMD_ALLOC_ANY, 0));
    pending_cmds.push_back(make_cmd(CMD_ALLOC_ANY, 0));
    pending_cmds.push_back(make_cmd(CMD_RESET, 0));
    pending_cmds.push_back(make_cmd(CMD_FREE, 0));
    pending_cmds[$].free_cpu_address = '0;
    pending_cmds[$].free_gpu_address = '0;
    pending_cmds[$].free_owner_tag = '0;
    pending_cmds.push_back(make_cmd(CMD_ALLOC_AT, 0));
    wait_drained();

    // one-slot heap with wrapping bases and visible GPU addresses
    set_heap(16'd1, '1, 64'hFFFF_FFFF_FFFF_FFF0, 1'b1, 11'd1, rand64());
    pending_cmds.push_back(make_cmd(CMD_ALLOC_ANY, 0));
    pending_cmds.push_back(make_cmd(CMD_ALLOC_ANY, 0));
    pending_cmds.push_back(make_cmd(CMD_ALLOC_AT, 1));
    pending_cmds.push_back(make_cmd(CMD_ALLOC_AT, 0));
    wait_drained();

    // raise the maximum to two, with a zero stride
    set_heap(16'd0, 64'h1000, 64'h2000, 1'b1, 11'd2, rand64());
    pending_cmds.push_back(make_cmd(CMD_ALLOC_ANY, 0));
    pending_cmds.push_back(make_cmd(CMD_FREE, 0));
    pending_cmds[$].free_cpu_address = 64'h1000;
    pending_cmds.push_back(make_cmd(CMD_ALLOC_AT, 0));
    pending_cmds.push_back(make_cmd(CMD_ALLOC_AT, 1));
    pending_cmds.push_back(make_cmd(CMD_RESET, 0));
    wait_drained();

    // back up the block with the receiver held off
    set_heap(16'd32, '0, '0, 1'b0, 11'd1024, '0);
    hold_off_cycles = 400;
    for (int i = 0; i < 40; i++) pending_cmds.push_back(make_cmd(CMD_FREE, i));
    pending_cmds.push_back(make_cmd(CMD_ALLOC_ANY, 0));
    pending_cmds.push_back(make_cmd(CMD_ALLOC_AT, 7));
    pending_cmds.push_back(make_cmd(CMD_RESET, 0));
    wait_drained();

    // random phases over several heap settings and idling patterns
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_heap(16'd64, rand64(), rand64(), 1'b1, 11'd8, rand64());
        1: set_heap(16'hFFFF, '0, '1, 1'b0, 11'd1024, '1);
        2: set_heap(16'(1 + $urandom_range(0, 254)), rand64(), rand64(), 1'b1,
                    11'(1 + $urandom_range(0, 31)), rand64());
        3: set_heap(16'd1, '1, rand64(), 1'b1, 11'd1, rand64());
        4: set_heap(16'd0, rand64(), rand64(), 1'b0, 11'd16, rand64());
        default: set_heap(16'($urandom()), rand64(), rand64(), 1'b1, 11'd1024, rand64());
      endcase
      case (ph % 3)
        0: begin send_idle_pct = 25; recv_idle_pct = 66; end
        1: begin send_idle_pct = 66; recv_idle_pct = 25; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (ph == 1) hold_off_cycles = 300;
      for (int chunk = 0; chunk < 2; chunk++) begin
        // sender pauses between chunks until all results are back
        for (int i = 0; i < 42; i++) pending_cmds.push_back(random_cmd());
        wait_drained();
      end
    end

    send_idle_pct = 0;
    recv_idle_pct = 0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (!failed) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
